[hw/rtl/qct_pkg.sv]
// qct_pkg: shared constants and controller/datapath handshake types
// for the quorum commit tracker. No dependencies.
package qct_pkg;

  localparam int MaxNodesDef  = 8;
  localparam int LogWindowDef = 16;
  localparam int CntW         = 5;   // member counts up to 16

  localparam logic [1:0] OpReport = 2'd0;
  localparam logic [1:0] OpAppend = 2'd1;
  localparam logic [1:0] OpQuery  = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNoLeader = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StBadPeer  = 2'd3;

  localparam logic [1:0] RegNodeCount = 2'd0;
  localparam logic [1:0] RegSelfId    = 2'd1;
  localparam logic [1:0] RegIsLeader  = 2'd2;
  localparam logic [1:0] RegTerm      = 2'd3;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic walk_start;
    logic walk_rd;
    logic walk_chk;
    logic commit_upd;
    logic maj_start;
    logic maj_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_adv;
    logic walk_end;
    logic skip_maj;
    logic maj_hit;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/qct_ram.sv]
// qct_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module qct_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[hw/rtl/qct_ctrl.sv]
// qct_ctrl: sequencing state machine for the commit tracker.
// Depends on qct_pkg (cmd_t, sts_t).
module qct_ctrl import qct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SExec  = 4'd1;
  localparam logic [3:0] SWst   = 4'd2;
  localparam logic [3:0] SWrd   = 4'd3;
  localparam logic [3:0] SWchk  = 4'd4;
  localparam logic [3:0] SWdone = 4'd5;
  localparam logic [3:0] SMst   = 4'd6;
  localparam logic [3:0] SMaj   = 4'd7;
  localparam logic [3:0] SOut   = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = SExec;
        end
      end
      SExec: begin
        cmd_o.exec = 1'b1;
        state_d = sts_i.need_adv ? SWst : SMst;
      end
      SWst: begin
        cmd_o.walk_start = 1'b1;
        state_d = SWrd;
      end
      SWrd: begin
        if (sts_i.walk_end) begin
          state_d = SWdone;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d = SWchk;
        end
      end
      SWchk: begin
        cmd_o.walk_chk = 1'b1;
        state_d = SWrd;
      end
      SWdone: begin
        cmd_o.commit_upd = 1'b1;
        state_d = SMst;
      end
      SMst: begin
        cmd_o.maj_start = 1'b1;
        state_d = sts_i.skip_maj ? SOut : SMaj;
      end
      SMaj: begin
        cmd_o.maj_step = 1'b1;
        if (sts_i.maj_hit) state_d = SOut;
      end
      SOut: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end
endmodule

[hw/rtl/qct_dp.sv]
// qct_dp: datapath of the commit tracker: config, match table, commit walk,
// majority search, output register. Depends on qct_pkg and qct_ram.
module qct_dp import qct_pkg::*; #(
  parameter int MAX_NODES  = MaxNodesDef,
  parameter int LOG_WINDOW = LogWindowDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic [1:0]   in_op_i,
  input  logic [2:0]   in_peer_i,
  input  logic [63:0]  in_index_i,
  input  logic [63:0]  in_term_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [131:0] out_data_o,
  input  cmd_t         cmd_i,
  output sts_t         sts_o
);
  localparam int SW = (LOG_WINDOW > 1) ? $clog2(LOG_WINDOW) : 1;
  localparam int JW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [SW-1:0] SlotLast = SW'(LOG_WINDOW - 1);

  logic [3:0]  node_count_q;
  logic [2:0]  self_id_q;
  logic        leader_q;
  logic [63:0] term_q;

  logic [63:0] pm_q [MAX_NODES];
  logic [63:0] last_q, commit_q, best_q, idx_q;
  logic [SW-1:0] last_slot_q, commit_slot_q, best_slot_q, idx_slot_q;
  logic [1:0]  op_q, status_q;
  logic [2:0]  peer_q;
  logic [63:0] ival_q, eterm_q, maj_q;
  logic        comm_q, moved_q;
  logic [JW-1:0] maj_j_q;
  logic        out_valid_q;
  logic [131:0] out_q;

  logic [CntW-1:0] mem_n, self_x, votes, pos, cnt_lt, cnt_le;
  logic [63:0] vals [MAX_NODES];
  logic [63:0] cand, rdata;
  logic        full, we, maj_hit;
  logic [SW-1:0] last_slot_nx;
  logic [1:0]  status_d;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    slot_inc = (s == SlotLast) ? '0 : s + SW'(1);
  endfunction

  always_comb begin
    if (node_count_q == 4'd0) mem_n = CntW'(1);
    else if ({1'b0, node_count_q} > CntW'(MAX_NODES)) mem_n = CntW'(MAX_NODES);
    else mem_n = {1'b0, node_count_q};
  end
  assign self_x = {2'b00, self_id_q};
  assign pos    = (mem_n - CntW'(1)) >> 1;

  // votes for the walk index: the leader plus matching peers
  always_comb begin
    votes = CntW'(1);
    for (int i = 0; i < MAX_NODES; i++) begin
      if (CntW'(i) < mem_n && CntW'(i) != self_x && pm_q[i] >= idx_q)
        votes = votes + CntW'(1);
    end
  end

  // rank test of one candidate per cycle for the majority match
  always_comb begin
    for (int i = 0; i < MAX_NODES; i++)
      vals[i] = (CntW'(i) == self_x) ? last_q : pm_q[i];
    cand   = vals[maj_j_q];
    cnt_lt = '0;
    cnt_le = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (CntW'(i) < mem_n) begin
        if (vals[i] < cand)  cnt_lt = cnt_lt + CntW'(1);
        if (vals[i] <= cand) cnt_le = cnt_le + CntW'(1);
      end
    end
    maj_hit = (cnt_lt <= pos) && (pos < cnt_le);
  end

  assign full = ((last_q - commit_q) >= 64'(LOG_WINDOW)) || (&last_q);
  assign last_slot_nx = slot_inc(last_slot_q);
  assign we = cmd_i.exec && leader_q && op_q == OpAppend && !full;

  always_comb begin
    status_d = StOk;
    if (op_q == OpReport || op_q == OpAppend) begin
      if (!leader_q) status_d = StNoLeader;
      else if (op_q == OpReport &&
               ({2'b00, peer_q} >= mem_n || peer_q == self_id_q))
        status_d = StBadPeer;
      else if (op_q == OpAppend && full) status_d = StFull;
    end
  end

  qct_ram #(.Width(64), .Depth(LOG_WINDOW)) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (last_slot_nx),
    .wdata_i (eterm_q),
    .re_i    (cmd_i.walk_rd),
    .raddr_i (idx_slot_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= 4'd1;
      self_id_q     <= '0;
      leader_q      <= 1'b0;
      term_q        <= '0;
      for (int i = 0; i < MAX_NODES; i++) pm_q[i] <= '0;
      last_q        <= '0;
      last_slot_q   <= '0;
      commit_q      <= '0;
      commit_slot_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegNodeCount: node_count_q <= cfg_data_i[3:0];
          RegSelfId:    self_id_q    <= cfg_data_i[2:0];
          RegIsLeader:  leader_q     <= cfg_data_i[0];
          RegTerm:      term_q       <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.exec && leader_q) begin
        if (op_q == OpReport && {2'b00, peer_q} < mem_n && peer_q != self_id_q)
          pm_q[JW'(peer_q)] <= ival_q;
        if (we) begin
          last_q      <= last_q + 64'd1;
          last_slot_q <= last_slot_nx;
        end
      end
      if (cmd_i.commit_upd && best_q > commit_q) begin
        commit_q      <= best_q;
        commit_slot_q <= best_slot_q;
      end
      if (cmd_i.out_load)           out_valid_q <= 1'b1;
      else if (out_ready_i)         out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q    <= in_op_i;
      peer_q  <= in_peer_i;
      ival_q  <= in_index_i;
      eterm_q <= in_term_i;
    end
    if (cmd_i.exec) begin
      moved_q  <= 1'b0;
      comm_q   <= (op_q == OpQuery) && ival_q != '0 && ival_q <= commit_q;
      status_q <= status_d;
    end
    if (cmd_i.walk_start) begin
      idx_q       <= commit_q + 64'd1;
      idx_slot_q  <= slot_inc(commit_slot_q);
      best_q      <= commit_q;
      best_slot_q <= commit_slot_q;
    end
    if (cmd_i.walk_chk) begin
      if (votes > (mem_n >> 1) && rdata == term_q) begin
        best_q      <= idx_q;
        best_slot_q <= idx_slot_q;
      end
      idx_q      <= idx_q + 64'd1;
      idx_slot_q <= slot_inc(idx_slot_q);
    end
    if (cmd_i.commit_upd) moved_q <= best_q > commit_q;
    if (cmd_i.maj_start) begin
      maj_j_q <= '0;
      maj_q   <= '0;
    end
    if (cmd_i.maj_step) begin
      if (maj_hit) maj_q <= cand;
      maj_j_q <= maj_j_q + JW'(1);
    end
    if (cmd_i.out_load) out_q <= {moved_q, comm_q, maj_q, commit_q, status_q};
  end

  // walk end: index past the last entry or wrapped past all ones
  // (window bound follows from appends)
  assign sts_o.need_adv = leader_q && (op_q == OpReport || op_q == OpAppend);
  assign sts_o.walk_end = (idx_q > last_q) || (idx_q == '0);
  assign sts_o.skip_maj = !leader_q;
  assign sts_o.maj_hit  = maj_hit;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

[hw/rtl/quorum_commit_tracker_top.sv]
// quorum_commit_tracker_top: leader-side commit tracker, top level.
// Depends on qct_pkg, qct_ctrl, qct_dp (which holds qct_ram).
//
// Usage:
//   Input stream s_axis: one request per operation. tuser carries op
//   (report, append, query); tdata carries peer, index_value, append term.
//   Output stream m_axis: one result per request with status, commit index,
//   majority match, query flag and advance flag.
//   Config channel cfg_*: register index and data, always ready; write it
//   only while no request is in flight.
// Sequence from acceptance to tvalid: an execute step, then for a report or
//   append as leader a walk start, a read and a check per uncommitted index
//   walked (at most LOG_WINDOW) and a commit update, then the majority rank
//   search over up to MAX_NODES candidates (skipped when not leader), then the
//   load into the output register, which waits while the receiver stalls.
//   The walk reads the term ring through its single registered read port.
//   Queries skip the walk. The controller returns to idle before the next accept.
// Reset clears config to defaults, match table, last and commit indices.
// A stalled receiver holds the result in the output register; the next
//   request is accepted and worked on, and waits before its own result load.
module quorum_commit_tracker_top import qct_pkg::*; #(
  parameter int MAX_NODES  = MaxNodesDef,
  parameter int LOG_WINDOW = LogWindowDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,   // peer, index_value, append term, zero pad
  input  logic [1:0]   s_axis_tuser,   // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata    // status, commit_out, majority_match,
                                       // is_committed, advanced, zero pad
);
  cmd_t cmd;
  sts_t sts;
  logic [131:0] out_data;

  assign cfg_ready_o = 1'b1;

  qct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qct_dp #(.MAX_NODES(MAX_NODES), .LOG_WINDOW(LOG_WINDOW)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_op_i     (s_axis_tuser),
    .in_peer_i   (s_axis_tdata[2:0]),
    .in_index_i  (s_axis_tdata[66:3]),
    .in_term_i   (s_axis_tdata[130:67]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign m_axis_tdata = {4'b0000, out_data};

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd)) else $error("more than one datapath command");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while busy");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten while stalled");
endmodule
